>>> src/mtd_pkg.sv
// shared types, codes and the token lookup table of the morse token decoder
package mtd_pkg;

   localparam int SYMBOL_WIDTH = 8;
   localparam int CHAR_WIDTH   = 7;
   localparam int STATUS_WIDTH = 2;
   localparam int MAX_SYMBOLS  = 6;
   localparam int COUNT_WIDTH  = 3;
   localparam int CODE_WIDTH   = 2;
   localparam int BUFFER_WIDTH = MAX_SYMBOLS * CODE_WIDTH;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD   = 2'd2;

   // text bytes with a meaning
   localparam logic [SYMBOL_WIDTH-1:0] BYTE_DOT   = 8'h2e;
   localparam logic [SYMBOL_WIDTH-1:0] BYTE_DASH  = 8'h2d;
   localparam logic [SYMBOL_WIDTH-1:0] BYTE_SLASH = 8'h2f;
   localparam logic [SYMBOL_WIDTH-1:0] BYTE_SPACE = 8'h20;

   // two-bit symbol codes in the token buffer
   localparam logic [CODE_WIDTH-1:0] SYM_NO = 2'd0;
   localparam logic [CODE_WIDTH-1:0] SYM_DT = 2'd1;
   localparam logic [CODE_WIDTH-1:0] SYM_DH = 2'd2;
   localparam logic [CODE_WIDTH-1:0] SYM_SL = 2'd3;

   typedef struct packed {
      logic                    emit;
      logic [CHAR_WIDTH-1:0]   decoded_char;
      logic [STATUS_WIDTH-1:0] status;
      logic                    final_result;
   } result_type;

   function automatic logic [CODE_WIDTH-1:0] symbol_code(input logic [SYMBOL_WIDTH-1:0] b);
      logic [CODE_WIDTH-1:0] c;
      case (b)
         BYTE_DOT:   c = SYM_DT;
         BYTE_DASH:  c = SYM_DH;
         BYTE_SLASH: c = SYM_SL;
         default:    c = SYM_NO;
      endcase
      return c;
   endfunction

   // first symbol sits in the low bits, so patterns read right to left
   // returns 0 for a pattern that is not in the table
   function automatic logic [CHAR_WIDTH-1:0] lookup(input logic [BUFFER_WIDTH-1:0] buffer);
      logic [CHAR_WIDTH-1:0] ch;
      case (buffer)
         {SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_DH, SYM_DT}: ch = 7'h61; // a
         {SYM_NO, SYM_NO, SYM_DT, SYM_DT, SYM_DT, SYM_DH}: ch = 7'h62; // b
         {SYM_NO, SYM_NO, SYM_DT, SYM_DH, SYM_DT, SYM_DH}: ch = 7'h63; // c
         {SYM_NO, SYM_NO, SYM_NO, SYM_DT, SYM_DT, SYM_DH}: ch = 7'h64; // d
         {SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_DT}: ch = 7'h65; // e
         {SYM_NO, SYM_NO, SYM_DT, SYM_DH, SYM_DT, SYM_DT}: ch = 7'h66; // f
         {SYM_NO, SYM_NO, SYM_NO, SYM_DT, SYM_DH, SYM_DH}: ch = 7'h67; // g
         {SYM_NO, SYM_NO, SYM_DT, SYM_DT, SYM_DT, SYM_DT}: ch = 7'h68; // h
         {SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_DT, SYM_DT}: ch = 7'h69; // i
         {SYM_NO, SYM_NO, SYM_DH, SYM_DH, SYM_DH, SYM_DT}: ch = 7'h6a; // j
         {SYM_NO, SYM_NO, SYM_NO, SYM_DH, SYM_DT, SYM_DH}: ch = 7'h6b; // k
         {SYM_NO, SYM_NO, SYM_DT, SYM_DT, SYM_DH, SYM_DT}: ch = 7'h6c; // l
         {SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_DH, SYM_DH}: ch = 7'h6d; // m
         {SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_DT, SYM_DH}: ch = 7'h6e; // n
         {SYM_NO, SYM_NO, SYM_NO, SYM_DH, SYM_DH, SYM_DH}: ch = 7'h6f; // o
         {SYM_NO, SYM_NO, SYM_DT, SYM_DH, SYM_DH, SYM_DT}: ch = 7'h70; // p
         {SYM_NO, SYM_NO, SYM_DH, SYM_DT, SYM_DH, SYM_DH}: ch = 7'h71; // q
         {SYM_NO, SYM_NO, SYM_NO, SYM_DT, SYM_DH, SYM_DT}: ch = 7'h72; // r
         {SYM_NO, SYM_NO, SYM_NO, SYM_DT, SYM_DT, SYM_DT}: ch = 7'h73; // s
         {SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_DH}: ch = 7'h74; // t
         {SYM_NO, SYM_NO, SYM_NO, SYM_DH, SYM_DT, SYM_DT}: ch = 7'h75; // u
         {SYM_NO, SYM_NO, SYM_DH, SYM_DT, SYM_DT, SYM_DT}: ch = 7'h76; // v
         {SYM_NO, SYM_NO, SYM_NO, SYM_DH, SYM_DH, SYM_DT}: ch = 7'h77; // w
         {SYM_NO, SYM_NO, SYM_DH, SYM_DT, SYM_DT, SYM_DH}: ch = 7'h78; // x
         {SYM_NO, SYM_NO, SYM_DH, SYM_DH, SYM_DT, SYM_DH}: ch = 7'h79; // y
         {SYM_NO, SYM_NO, SYM_DT, SYM_DT, SYM_DH, SYM_DH}: ch = 7'h7a; // z
         {SYM_NO, SYM_DH, SYM_DH, SYM_DH, SYM_DH, SYM_DH}: ch = 7'h30; // 0
         {SYM_NO, SYM_DH, SYM_DH, SYM_DH, SYM_DH, SYM_DT}: ch = 7'h31; // 1
         {SYM_NO, SYM_DH, SYM_DH, SYM_DH, SYM_DT, SYM_DT}: ch = 7'h32; // 2
         {SYM_NO, SYM_DH, SYM_DH, SYM_DT, SYM_DT, SYM_DT}: ch = 7'h33; // 3
         {SYM_NO, SYM_DH, SYM_DT, SYM_DT, SYM_DT, SYM_DT}: ch = 7'h34; // 4
         {SYM_NO, SYM_DT, SYM_DT, SYM_DT, SYM_DT, SYM_DT}: ch = 7'h35; // 5
         {SYM_NO, SYM_DT, SYM_DT, SYM_DT, SYM_DT, SYM_DH}: ch = 7'h36; // 6
         {SYM_NO, SYM_DT, SYM_DT, SYM_DT, SYM_DH, SYM_DH}: ch = 7'h37; // 7
         {SYM_NO, SYM_DT, SYM_DT, SYM_DH, SYM_DH, SYM_DH}: ch = 7'h38; // 8
         {SYM_NO, SYM_DT, SYM_DH, SYM_DH, SYM_DH, SYM_DH}: ch = 7'h39; // 9
         {SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_SL}: ch = 7'h20; // space
         {SYM_NO, SYM_NO, SYM_NO, SYM_NO, SYM_SL, SYM_SL}: ch = 7'h2e; // period
         {SYM_DT, SYM_DT, SYM_DH, SYM_DH, SYM_DT, SYM_DT}: ch = 7'h3f; // question mark
         default:                                          ch = '0;
      endcase
      return ch;
   endfunction

endpackage

>>> src/mtd_channel_if.sv
// valid/ready channel interfaces for text bytes and decoded results
interface mtd_req_if;
   logic                                valid;
   logic                                ready;
   logic [mtd_pkg::SYMBOL_WIDTH-1:0]    symbol;
   logic                                message_end;

   modport source (output valid, output symbol, output message_end, input ready);
   modport sink   (input valid, input symbol, input message_end, output ready);
endinterface

interface mtd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mtd_pkg::CHAR_WIDTH-1:0]      decoded_char;
   logic [mtd_pkg::STATUS_WIDTH-1:0]    status;
   logic                                final_result;

   modport source (output valid, output decoded_char, output status, output final_result,
                   input ready);
   modport sink   (input valid, input decoded_char, input status, input final_result,
                   output ready);
endinterface

>>> src/mtd_token_stage.sv
// token collector: symbol buffer, count and error flag, plus the token lookup
module mtd_token_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [mtd_pkg::SYMBOL_WIDTH-1:0] symbol,
   input  logic                             message_end,
   output mtd_pkg::result_type              result
);
   import mtd_pkg::*;

   logic [BUFFER_WIDTH-1:0] buffer_ff, buffer_in, buffer_upd;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in, count_upd;
   logic                    invalid_ff, invalid_in, invalid_upd;
   logic [CODE_WIDTH-1:0]   code;
   logic [CHAR_WIDTH-1:0]   found;
   logic                    is_space;

   always_comb begin
      code        = symbol_code(symbol);
      is_space    = (symbol == BYTE_SPACE);
      buffer_upd  = buffer_ff;
      count_upd   = count_ff;
      invalid_upd = invalid_ff;
      if (!is_space) begin
         if (code == SYM_NO) begin
            invalid_upd = 1'b1;
         end else if (count_ff >= COUNT_WIDTH'(MAX_SYMBOLS)) begin
            // seventh symbol is dropped but spoils the token
            invalid_upd = 1'b1;
         end else begin
            buffer_upd = buffer_ff | ({{(BUFFER_WIDTH-CODE_WIDTH){1'b0}}, code}
                                      << {count_ff, 1'b0});
            count_upd  = count_ff + 1'b1;
         end
      end

      found               = lookup(buffer_upd);
      result.emit         = is_space || message_end;
      result.final_result = message_end;
      result.decoded_char = '0;
      if (invalid_upd) begin
         result.status = STATUS_BAD;
      end else if (count_upd == '0) begin
         result.status = STATUS_EMPTY;
      end else if (found != '0) begin
         result.status       = STATUS_OK;
         result.decoded_char = found;
      end else begin
         result.status = STATUS_BAD;
      end

      buffer_in  = buffer_ff;
      count_in   = count_ff;
      invalid_in = invalid_ff;
      if (accept) begin
         if (result.emit) begin
            buffer_in  = '0;
            count_in   = '0;
            invalid_in = 1'b0;
         end else begin
            buffer_in  = buffer_upd;
            count_in   = count_upd;
            invalid_in = invalid_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff  <= '0;
         count_ff   <= '0;
         invalid_ff <= 1'b0;
      end else begin
         buffer_ff  <= buffer_in;
         count_ff   <= count_in;
         invalid_ff <= invalid_in;
      end
   end

endmodule

>>> src/morse_token_decoder_unit.sv
// morse token decoder top level: token collector feeding a result register
//
// req_ch carries one text byte per transfer: '.', '-' and '/' are symbols,
// a space ends the current token, and message_end marks the last byte of
// a message (a symbol on that byte is collected first, then the token ends).
// rsp_ch carries one result per ended token: decoded_char, status
// (ok, empty token, unknown/over-long/foreign token) and final_result.
// Bytes that do not end a token give no result.
//
// The result of a byte accepted at one edge is valid on rsp_ch after that
// edge. Throughput is one byte per cycle while no result stalls, set by the
// combinational collect-and-lookup path in front of the result register.
// While the result register holds an untaken result, req_ch.ready follows
// rsp_ch.ready, so a stalled receiver stalls the sender in the same cycle
// and a byte is still taken in the cycle the pending result leaves.
// Synchronous reset empties the result register and clears the token.
module morse_token_decoder_unit (
   input logic      clock,
   input logic      reset,
   mtd_req_if.sink  req_ch,
   mtd_rsp_if.source rsp_ch
);
   import mtd_pkg::*;

   result_type              result;
   logic                    accept;
   logic                    valid_ff, valid_in;
   logic [CHAR_WIDTH-1:0]   char_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic                    final_ff;

   assign req_ch.ready = !valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   mtd_token_stage u_token (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .symbol      (req_ch.symbol),
      .message_end (req_ch.message_end),
      .result      (result)
   );

   always_comb begin
      valid_in = valid_ff && !rsp_ch.ready;
      if (accept && result.emit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload only loads on a transfer that ends a token
   always_ff @(posedge clock) begin
      if (accept && result.emit) begin
         char_ff   <= result.decoded_char;
         status_ff <= result.status;
         final_ff  <= result.final_result;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.decoded_char = char_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.final_result = final_ff;

endmodule

>>> src/mtd_port_checker.sv
// port-level checks of the morse token decoder and their binding
module mtd_port_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [mtd_pkg::SYMBOL_WIDTH-1:0] req_symbol,
   input logic                             req_message_end,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [mtd_pkg::CHAR_WIDTH-1:0]   rsp_decoded_char,
   input logic [mtd_pkg::STATUS_WIDTH-1:0] rsp_status,
   input logic                             rsp_final_result
);
   import mtd_pkg::*;

   // a transfer that ends a token shows its result right after
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_symbol == BYTE_SPACE || req_message_end)
      |=> rsp_valid && rsp_final_result == $past(req_message_end))
      else $error("ended token did not produce a result");

   // error results carry no character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_decoded_char == '0)
      else $error("error result carries a character");

   // an ok result always names a character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_decoded_char != '0)
      else $error("ok result without a character");

   // a pending result blocks input until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while a result is stalled");

endmodule

bind morse_token_decoder_unit mtd_port_checker u_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_symbol       (req_ch.symbol),
   .req_message_end  (req_ch.message_end),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_decoded_char (rsp_ch.decoded_char),
   .rsp_status       (rsp_ch.status),
   .rsp_final_result (rsp_ch.final_result)
);

>>> test/token_result_checker.sv
`timescale 1ns / 1ps
// result checker: predicts decoded tokens from accepted text bytes and compares each result
module token_result_checker (
   input  logic clock,
   input  logic reset,
   mtd_req_if   req_ch,
   mtd_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   results_due,
   output int   ok_count,
   output int   empty_count,
   output int   reject_count
);
   import mtd_pkg::*;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0]   decoded_char;
      logic [STATUS_WIDTH-1:0] status;
      logic                    final_result;
   } decoded_type;

   decoded_type             due_results[$];
   logic [BUFFER_WIDTH-1:0] token_bits;
   logic [COUNT_WIDTH-1:0]  token_len;
   logic                    token_broken;
   int                      errors = 0;
   int                      n_ok = 0;
   int                      n_empty = 0;
   int                      n_reject = 0;
   int                      due_level = 0;

   assign mismatch_count = errors;
   assign results_due    = due_level;
   assign ok_count       = n_ok;
   assign empty_count    = n_empty;
   assign reject_count   = n_reject;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   // spell the collected token as dots, dashes and slashes, then look it up
   function automatic logic [7:0] char_of_token(input logic [BUFFER_WIDTH-1:0] bits,
                                                input logic [COUNT_WIDTH-1:0] len);
      string      pattern;
      logic [7:0] ch;
      pattern = "";
      for (int i = 0; i < len; i++) begin
         case (bits[2*i +: CODE_WIDTH])
            SYM_DT:  pattern = {pattern, "."};
            SYM_DH:  pattern = {pattern, "-"};
            default: pattern = {pattern, "/"};
         endcase
      end
      case (pattern)
         ".-":     ch = "a";
         "-...":   ch = "b";
         "-.-.":   ch = "c";
         "-..":    ch = "d";
         ".":      ch = "e";
         "..-.":   ch = "f";
         "--.":    ch = "g";
         "....":   ch = "h";
         "..":     ch = "i";
         ".---":   ch = "j";
         "-.-":    ch = "k";
         ".-..":   ch = "l";
         "--":     ch = "m";
         "-.":     ch = "n";
         "---":    ch = "o";
         ".--.":   ch = "p";
         "--.-":   ch = "q";
         ".-.":    ch = "r";
         "...":    ch = "s";
         "-":      ch = "t";
         "..-":    ch = "u";
         "...-":   ch = "v";
         ".--":    ch = "w";
         "-..-":   ch = "x";
         "-.--":   ch = "y";
         "--..":   ch = "z";
         "-----":  ch = "0";
         ".----":  ch = "1";
         "..---":  ch = "2";
         "...--":  ch = "3";
         "....-":  ch = "4";
         ".....":  ch = "5";
         "-....":  ch = "6";
         "--...":  ch = "7";
         "---..":  ch = "8";
         "----.":  ch = "9";
         "/":      ch = " ";
         "//":     ch = ".";
         "..--..": ch = "?";
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

   task automatic clear_token();
      token_bits   = '0;
      token_len    = '0;
      token_broken = 1'b0;
   endtask

   // one accepted text byte: grow the token, and on a space or a last byte close it
   task automatic absorb_byte(input logic [SYMBOL_WIDTH-1:0] b, input logic last);
      logic [CODE_WIDTH-1:0] code;
      logic [7:0]            ch;
      decoded_type           got;
      case (b)
         BYTE_DOT:   code = SYM_DT;
         BYTE_DASH:  code = SYM_DH;
         BYTE_SLASH: code = SYM_SL;
         default:    code = SYM_NO;
      endcase
      if (b != BYTE_SPACE) begin
         // foreign bytes and symbols past the sixth spoil the token
         if (code == SYM_NO || token_len >= MAX_SYMBOLS) begin
            token_broken = 1'b1;
         end else begin
            token_bits[2*token_len +: CODE_WIDTH] = code;
            token_len = token_len + 1'b1;
         end
      end
      if (b == BYTE_SPACE || last) begin
         got.decoded_char = '0;
         got.final_result = last;
         if (token_broken) begin
            got.status = STATUS_BAD;
         end else if (token_len == 0) begin
            got.status = STATUS_EMPTY;
         end else begin
            ch = char_of_token(token_bits, token_len);
            if (ch == 8'h00) begin
               got.status = STATUS_BAD;
            end else begin
               got.status       = STATUS_OK;
               got.decoded_char = ch[CHAR_WIDTH-1:0];
            end
         end
         due_results = {due_results, got};
         clear_token();
      end
   endtask

   always @(posedge clock) begin
      decoded_type want;
      if (reset) begin
         due_results.delete();
         clear_token();
      end else begin
         // a result can never come from a byte taken at this same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result char %h status %0d final %0b",
                  rsp_ch.decoded_char, rsp_ch.status, rsp_ch.final_result));
            end else begin
               want = due_results.pop_front();
               if (rsp_ch.decoded_char !== want.decoded_char)
                  report_mismatch($sformatf("decoded_char %h, want %h",
                     rsp_ch.decoded_char, want.decoded_char));
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                     rsp_ch.status, want.status));
               if (rsp_ch.final_result !== want.final_result)
                  report_mismatch($sformatf("final_result %0b, want %0b",
                     rsp_ch.final_result, want.final_result));
               case (want.status)
                  STATUS_OK:    n_ok++;
                  STATUS_EMPTY: n_empty++;
                  default:      n_reject++;
               endcase
            end
         end
         if (req_ch.valid && req_ch.ready)
            absorb_byte(req_ch.symbol, req_ch.message_end);
      end
      due_level <= due_results.size();
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// testbench top: drives text bytes and result backpressure, gives the verdict
module tb_top;
   import mtd_pkg::*;

   localparam int TOTAL_BYTES     = 1450;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int mismatch_count;
   int results_due;
   int ok_count;
   int empty_count;
   int reject_count;
   int bytes_sent = 0;
   int idle_cycles = 0;
   bit steady_flow = 1'b0;
   bit hold_off_go = 1'b0;

   always #5 clock = ~clock;

   mtd_req_if req_ch ();
   mtd_rsp_if rsp_ch ();

   morse_token_decoder_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   token_result_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .results_due    (results_due),
      .ok_count       (ok_count),
      .empty_count    (empty_count),
      .reject_count   (reject_count)
   );

   // receiver: random stalls, steady stretches and one long hold-off
   initial begin : result_taker
      int r;
      int n;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_go) begin
            rsp_ch.ready <= 1'b0;
            hold_off_go = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (steady_flow) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_ch.ready <= 1'b1;
               n = $urandom_range(1, 8);
            end else if (r < 93) begin
               rsp_ch.ready <= 1'b0;
               n = $urandom_range(1, 3);
            end else begin
               rsp_ch.ready <= 1'b0;
               n = $urandom_range(8, 30);
            end
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("no transfer for %0d cycles", IDLE_LIMIT);
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(5, 25);
   endfunction

   function automatic logic [SYMBOL_WIDTH-1:0] pick_mark(input bit with_slash);
      int r;
      r = $urandom_range(0, with_slash ? 2 : 1);
      if (r == 0)
         return BYTE_DOT;
      else if (r == 1)
         return BYTE_DASH;
      else
         return BYTE_SLASH;
   endfunction

   // called at the edge where the previous byte was taken
   task automatic send_byte(input logic [SYMBOL_WIDTH-1:0] b, input logic last);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.symbol      <= b;
      req_ch.message_end <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], last && (i == s.len() - 1));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed tokens, some over-long, foreign or pure noise
   task automatic send_random_token();
      logic [SYMBOL_WIDTH-1:0] body[$];
      logic [SYMBOL_WIDTH-1:0] b;
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         n = $urandom_range(1, 4);
         repeat (n) body = {body, pick_mark(1'b0)};
      end else if (r < 60) begin
         repeat (5) body = {body, pick_mark(1'b0)};
      end else if (r < 65) begin
         body = {BYTE_DOT, BYTE_DOT, BYTE_DASH, BYTE_DASH, BYTE_DOT, BYTE_DOT};
      end else if (r < 73) begin
         n = $urandom_range(1, 2);
         repeat (n) body = {body, BYTE_SLASH};
      end else if (r < 80) begin
         n = $urandom_range(6, 10);
         repeat (n) body = {body, pick_mark(1'b1)};
      end else if (r < 93 && r >= 85) begin
         n = $urandom_range(1, 4);
         repeat (n) body = {body, pick_mark(1'b0)};
         do
            b = SYMBOL_WIDTH'($urandom_range(0, 255));
         while (b == BYTE_DOT || b == BYTE_DASH || b == BYTE_SLASH || b == BYTE_SPACE);
         body.insert($urandom_range(0, n), b);
      end else if (r >= 93) begin
         n = $urandom_range(1, 3);
         repeat (n) body = {body, SYMBOL_WIDTH'($urandom_range(0, 255))};
      end
      // empty tokens fall through with no body
      r = $urandom_range(0, 99);
      if (r >= 85 && body.size() > 0) begin
         for (int i = 0; i < body.size(); i++)
            send_byte(body[i], i == body.size() - 1);
      end else begin
         foreach (body[i]) send_byte(body[i], 1'b0);
         send_byte(BYTE_SPACE, r >= 70);
      end
   endtask

   initial begin : text_source
      int tokens;
      bit held;
      bit paused;
      tokens = 0;
      held   = 1'b0;
      paused = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.symbol      = '0;
      req_ch.message_end = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_text("..--..", 1'b1);   // longest table entry, closed by a marked symbol
      send_text("/ ", 1'b0);       // word gap decodes to a space
      send_text("//", 1'b1);       // period
      send_text(" ", 1'b0);        // empty token
      send_text(" ", 1'b1);        // empty token on a marked space
      send_byte(8'h00, 1'b0);      // foreign byte spoils the token
      send_byte(8'hff, 1'b1);      // foreign byte marked last closes at once
      send_text("-------", 1'b1);  // seventh symbol makes it over-long
      send_text("..--", 1'b1);     // pattern not in the table
      wait_drained();

      while (bytes_sent < TOTAL_BYTES) begin
         if (tokens % 16 == 0)
            steady_flow = ($urandom_range(0, 3) == 0);
         if (!held && bytes_sent > TOTAL_BYTES / 3) begin
            // receiver holds off while bytes keep coming, so the input stalls
            held = 1'b1;
            hold_off_go = 1'b1;
            steady_flow = 1'b1;
            repeat (30) send_random_token();
            steady_flow = 1'b0;
         end
         if (!paused && bytes_sent > 2 * TOTAL_BYTES / 3) begin
            paused = 1'b1;
            wait_drained();
         end
         send_random_token();
         tokens++;
      end

      wait_drained();
      $display("covered %0d text bytes in %0d random tokens after the directed set",
         bytes_sent, tokens);
      $display("results: %0d decoded, %0d empty, %0d rejected, %0d mismatches",
         ok_count, empty_count, reject_count, mismatch_count);
      if (mismatch_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
